FILE: hdl/mahd_pkg.sv
// Shared types, codes and lookup tables for the MPEG audio header decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mahd_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] SYNC_MASK = 8'hE0;
   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_3    = 8'h33;
   localparam logic [7:0] CHAR_T    = 8'h54;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_G    = 8'h47;

   localparam logic [3:0]  BITRATE_BAD     = 4'hF;
   localparam logic [1:0]  FS_RESERVED     = 2'd3;
   localparam logic [1:0]  MODE_SINGLE     = 2'd3;
   localparam logic [1:0]  VERSION_MPEG1   = 2'd3;
   localparam logic [10:0] MAX_FRAME_BYTES = 11'd1441;

   typedef enum logic [2:0] {
      KIND_AUDIO    = 3'd0,
      KIND_ID3V2    = 3'd1,
      KIND_ID3V1    = 3'd2,
      KIND_PAD      = 3'd3,
      KIND_ID3FRAME = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [4:0] hdr_one;
      logic [7:0] hdr_two;
      logic [7:0] hdr_three;
   } parse_type;

   typedef struct packed {
      kind_type    kind;
      logic        is_mpeg_one;
      logic [1:0]  layer_code;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [7:0]  hdr_three;
      logic [4:0]  flag_bits;
      logic [10:0] base_length;
      logic        header_error;
   } lookup_type;

   typedef struct packed {
      kind_type    kind;
      logic        is_mpeg_one;
      logic [1:0]  layer_code;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [1:0]  channel_mode;
      logic        is_stereo;
      logic [1:0]  mode_extension;
      logic [1:0]  emphasis_code;
      logic [4:0]  flag_bits;
      logic [10:0] frame_bytes;
      logic        header_error;
   } result_type;

   function automatic logic [8:0] bitrate_lookup(input logic [3:0] idx);
      logic [8:0] kbps;
      case (idx)
         4'd1:    kbps = 9'd32;
         4'd2:    kbps = 9'd40;
         4'd3:    kbps = 9'd48;
         4'd4:    kbps = 9'd56;
         4'd5:    kbps = 9'd64;
         4'd6:    kbps = 9'd80;
         4'd7:    kbps = 9'd96;
         4'd8:    kbps = 9'd112;
         4'd9:    kbps = 9'd128;
         4'd10:   kbps = 9'd160;
         4'd11:   kbps = 9'd192;
         4'd12:   kbps = 9'd224;
         4'd13:   kbps = 9'd256;
         4'd14:   kbps = 9'd320;
         default: kbps = 9'd0;
      endcase
      return kbps;
   endfunction

   function automatic logic [15:0] sample_rate_lookup(input logic [1:0] idx);
      logic [15:0] hz;
      case (idx)
         2'd0:    hz = 16'd44100;
         2'd1:    hz = 16'd48000;
         2'd2:    hz = 16'd32000;
         default: hz = 16'd0;
      endcase
      return hz;
   endfunction

   // Floor of 144000 * kbps / hz, without the padding byte.
   function automatic logic [10:0] base_length_lookup(input logic [3:0] br_idx,
                                                      input logic [1:0] fs_idx);
      logic [10:0] len;
      len = 11'd0;
      case (fs_idx)
         2'd0: begin
            case (br_idx)
               4'd1:    len = 11'd104;
               4'd2:    len = 11'd130;
               4'd3:    len = 11'd156;
               4'd4:    len = 11'd182;
               4'd5:    len = 11'd208;
               4'd6:    len = 11'd261;
               4'd7:    len = 11'd313;
               4'd8:    len = 11'd365;
               4'd9:    len = 11'd417;
               4'd10:   len = 11'd522;
               4'd11:   len = 11'd626;
               4'd12:   len = 11'd731;
               4'd13:   len = 11'd835;
               4'd14:   len = 11'd1044;
               default: len = 11'd0;
            endcase
         end
         2'd1: begin
            case (br_idx)
               4'd1:    len = 11'd96;
               4'd2:    len = 11'd120;
               4'd3:    len = 11'd144;
               4'd4:    len = 11'd168;
               4'd5:    len = 11'd192;
               4'd6:    len = 11'd240;
               4'd7:    len = 11'd288;
               4'd8:    len = 11'd336;
               4'd9:    len = 11'd384;
               4'd10:   len = 11'd480;
               4'd11:   len = 11'd576;
               4'd12:   len = 11'd672;
               4'd13:   len = 11'd768;
               4'd14:   len = 11'd960;
               default: len = 11'd0;
            endcase
         end
         2'd2: begin
            case (br_idx)
               4'd1:    len = 11'd144;
               4'd2:    len = 11'd180;
               4'd3:    len = 11'd216;
               4'd4:    len = 11'd252;
               4'd5:    len = 11'd288;
               4'd6:    len = 11'd360;
               4'd7:    len = 11'd432;
               4'd8:    len = 11'd504;
               4'd9:    len = 11'd576;
               4'd10:   len = 11'd720;
               4'd11:   len = 11'd864;
               4'd12:   len = 11'd1008;
               4'd13:   len = 11'd1152;
               4'd14:   len = 11'd1440;
               default: len = 11'd0;
            endcase
         end
         default: len = 11'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/mahd_classify.sv
// First pipeline stage: classifies the four bytes and keeps the header bits.
// Depends on mahd_pkg.
`default_nettype none

module mahd_classify (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                up_valid,
   input  wire logic [7:0]          byte_zero,
   input  wire logic [7:0]          byte_one,
   input  wire logic [7:0]          byte_two,
   input  wire logic [7:0]          byte_three,
   output      logic                up_stall,
   output      logic                dn_valid,
   output      mahd_pkg::parse_type dn_data,
   input  wire logic                dn_stall
);
   import mahd_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   parse_type data_ff;
   parse_type data_in;

   always_comb begin
      data_in.hdr_one   = byte_one[4:0];
      data_in.hdr_two   = byte_two;
      data_in.hdr_three = byte_three;
      if (byte_zero == SYNC_BYTE && (byte_one & SYNC_MASK) == SYNC_MASK) begin
         data_in.kind = KIND_AUDIO;
      end else if (byte_zero == CHAR_I && byte_one == CHAR_D && byte_two == CHAR_3) begin
         data_in.kind = KIND_ID3V2;
      end else if (byte_zero == CHAR_T && byte_one == CHAR_A && byte_two == CHAR_G) begin
         data_in.kind = KIND_ID3V1;
      end else if (byte_zero == 8'h00) begin
         data_in.kind = KIND_PAD;
      end else begin
         data_in.kind = KIND_ID3FRAME;
      end
   end

   assign up_stall = valid_ff && dn_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && !up_stall) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

FILE: hdl/mahd_lookup.sv
// Second pipeline stage: bitrate, sample-rate and frame-length table lookups.
// Depends on mahd_pkg.
`default_nettype none

module mahd_lookup (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   input  wire mahd_pkg::parse_type  up_data,
   output      logic                 up_stall,
   output      logic                 dn_valid,
   output      mahd_pkg::lookup_type dn_data,
   input  wire logic                 dn_stall
);
   import mahd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   lookup_type data_ff;
   lookup_type data_in;
   logic [3:0] br_idx;
   logic [1:0] fs_idx;

   assign br_idx = up_data.hdr_two[7:4];
   assign fs_idx = up_data.hdr_two[3:2];

   always_comb begin
      data_in.kind           = up_data.kind;
      data_in.is_mpeg_one    = (up_data.hdr_one[4:3] == VERSION_MPEG1);
      data_in.layer_code     = up_data.hdr_one[2:1];
      data_in.bitrate_kbps   = bitrate_lookup(br_idx);
      data_in.sample_rate_hz = sample_rate_lookup(fs_idx);
      data_in.hdr_three      = up_data.hdr_three;
      data_in.flag_bits      = {up_data.hdr_three[2], up_data.hdr_three[3],
                                up_data.hdr_two[0], up_data.hdr_two[1],
                                up_data.hdr_one[0]};
      data_in.base_length    = base_length_lookup(br_idx, fs_idx);
      data_in.header_error   = (br_idx == BITRATE_BAD) || (fs_idx == FS_RESERVED);
   end

   assign up_stall = valid_ff && dn_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && !up_stall) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

FILE: hdl/mahd_format.sv
// Third pipeline stage: adds the padding byte, clears fields of non-audio
// beats and holds the result register. Depends on mahd_pkg.
`default_nettype none

module mahd_format (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   input  wire mahd_pkg::lookup_type up_data,
   output      logic                 up_stall,
   output      logic                 dn_valid,
   output      mahd_pkg::result_type dn_data,
   input  wire logic                 dn_stall
);
   import mahd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;
   result_type data_in;

   always_comb begin
      data_in      = '0;
      data_in.kind = up_data.kind;
      if (up_data.kind == KIND_AUDIO) begin
         data_in.is_mpeg_one    = up_data.is_mpeg_one;
         data_in.layer_code     = up_data.layer_code;
         data_in.bitrate_kbps   = up_data.bitrate_kbps;
         data_in.sample_rate_hz = up_data.sample_rate_hz;
         data_in.channel_mode   = up_data.hdr_three[7:6];
         data_in.is_stereo      = (up_data.hdr_three[7:6] != MODE_SINGLE);
         data_in.mode_extension = up_data.hdr_three[5:4];
         data_in.emphasis_code  = up_data.hdr_three[1:0];
         data_in.flag_bits      = up_data.flag_bits;
         data_in.header_error   = up_data.header_error;
         if (!up_data.header_error) begin
            data_in.frame_bytes = up_data.base_length + {10'd0, up_data.flag_bits[1]};
         end
      end
   end

   assign up_stall = valid_ff && dn_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && !up_stall) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

`ifndef SYNTHESIS
   a_error_no_length: assert property (@(posedge clock) disable iff (reset)
      dn_valid && dn_data.header_error |-> dn_data.frame_bytes == 11'd0)
      else $error("Erroneous header carries a nonzero frame length.");

   a_other_kinds_clear: assert property (@(posedge clock) disable iff (reset)
      dn_valid && dn_data.kind != KIND_AUDIO |->
         dn_data.frame_bytes == 11'd0 && dn_data.bitrate_kbps == 9'd0 &&
         dn_data.sample_rate_hz == 16'd0 && dn_data.flag_bits == 5'd0 &&
         !dn_data.header_error)
      else $error("Non-audio beat carries decoded header fields.");

   a_good_header_sane: assert property (@(posedge clock) disable iff (reset)
      dn_valid && dn_data.kind == KIND_AUDIO && !dn_data.header_error |->
         dn_data.sample_rate_hz != 16'd0 && dn_data.frame_bytes <= MAX_FRAME_BYTES)
      else $error("Valid audio header has no sample rate or an oversized frame.");
`endif

endmodule

`default_nettype wire

FILE: hdl/mpeg_audio_header_decode.sv
// MPEG audio header decoder, top level: three pipeline stages in a chain.
// Depends on mahd_pkg, mahd_classify, mahd_lookup and mahd_format.
//
// The decoder accepts one four-byte beat per clock while req_stall is low and
// returns one result beat per input beat, in order; each beat is registered in
// the classify, table lookup and format stages before it is presented. The rate
// is one beat per cycle while no stall holds; the three register stages each
// hold one beat, and frame lengths come from a constant table, so no divider
// limits the rate. A stall on the result side holds the result register; an
// earlier stage holds only while it and every later stage are full and rsp_stall
// is high, so req_stall rises in the same cycle as rsp_stall once all are full.
`default_nettype none

module mpeg_audio_header_decode (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_byte_zero,
   input  wire logic [7:0]  req_byte_one,
   input  wire logic [7:0]  req_byte_two,
   input  wire logic [7:0]  req_byte_three,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_kind,
   output      logic        rsp_is_mpeg_one,
   output      logic [1:0]  rsp_layer_code,
   output      logic [8:0]  rsp_bitrate_kbps,
   output      logic [15:0] rsp_sample_rate_hz,
   output      logic [1:0]  rsp_channel_mode,
   output      logic        rsp_is_stereo,
   output      logic [1:0]  rsp_mode_extension,
   output      logic [1:0]  rsp_emphasis_code,
   output      logic [4:0]  rsp_flag_bits,
   output      logic [10:0] rsp_frame_bytes,
   output      logic        rsp_header_error
);
   import mahd_pkg::*;

   logic       parse_valid;
   logic       parse_stall;
   parse_type  parse_data;
   logic       lookup_valid;
   logic       lookup_stall;
   lookup_type lookup_data;
   result_type result;

   mahd_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .byte_zero  (req_byte_zero),
      .byte_one   (req_byte_one),
      .byte_two   (req_byte_two),
      .byte_three (req_byte_three),
      .up_stall   (req_stall),
      .dn_valid   (parse_valid),
      .dn_data    (parse_data),
      .dn_stall   (parse_stall)
   );

   mahd_lookup u_lookup (
      .clock    (clock),
      .reset    (reset),
      .up_valid (parse_valid),
      .up_data  (parse_data),
      .up_stall (parse_stall),
      .dn_valid (lookup_valid),
      .dn_data  (lookup_data),
      .dn_stall (lookup_stall)
   );

   mahd_format u_format (
      .clock    (clock),
      .reset    (reset),
      .up_valid (lookup_valid),
      .up_data  (lookup_data),
      .up_stall (lookup_stall),
      .dn_valid (rsp_valid),
      .dn_data  (result),
      .dn_stall (rsp_stall)
   );

   assign rsp_kind           = result.kind;
   assign rsp_is_mpeg_one    = result.is_mpeg_one;
   assign rsp_layer_code     = result.layer_code;
   assign rsp_bitrate_kbps   = result.bitrate_kbps;
   assign rsp_sample_rate_hz = result.sample_rate_hz;
   assign rsp_channel_mode   = result.channel_mode;
   assign rsp_is_stereo      = result.is_stereo;
   assign rsp_mode_extension = result.mode_extension;
   assign rsp_emphasis_code  = result.emphasis_code;
   assign rsp_flag_bits      = result.flag_bits;
   assign rsp_frame_bytes    = result.frame_bytes;
   assign rsp_header_error   = result.header_error;

endmodule

`default_nettype wire
